@@ rtl/lat_pkg.sv @@
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types and constants of the line accumulation tile.
// ----------------------------------------------------------------------------
package lat_pkg;

  localparam int TILE_SIDE  = 256;
  localparam int TILE_WORDS = TILE_SIDE * TILE_SIDE;
  localparam int TILE_AW    = $clog2(TILE_WORDS);
  localparam int QDEPTH     = 2;

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [2:0] REG_BRIGHTNESS  = 3'd0;
  localparam logic [2:0] REG_COLOR_RED   = 3'd1;
  localparam logic [2:0] REG_COLOR_GREEN = 3'd2;
  localparam logic [2:0] REG_COLOR_BLUE  = 3'd3;
  localparam logic [2:0] REG_COLOR_ALPHA = 3'd4;

  localparam logic [31:0] BRIGHTNESS_RST  = 32'h0003_FFFF;
  localparam logic [7:0]  COLOR_RED_RST   = 8'd255;
  localparam logic [7:0]  COLOR_GREEN_RST = 8'd190;
  localparam logic [7:0]  COLOR_BLUE_RST  = 8'd100;
  localparam logic [7:0]  COLOR_ALPHA_RST = 8'd255;

  typedef struct packed {
    logic        kind;
    logic [15:0] line_x_start;
    logic [15:0] line_y_start;
    logic [15:0] line_x_end;
    logic [15:0] line_y_end;
    logic [7:0]  read_col;
    logic [7:0]  read_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_item_t;

  typedef struct packed {
    logic [31:0] brightness;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
    logic [7:0]  color_alpha;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic               y_major;
    logic [15:0]        m0;
    logic [15:0]        d;
    logic [TILE_AW-1:0] raddr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

@@ rtl/line_accumulation_tile_unit.sv @@
// ----------------------------------------------------------------------------
// line_accumulation_tile_unit
// 256x256 tile of capped 32-bit brightness accumulators fed by line draws.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item and raise start; the item is taken at an edge where
//   start is high and busy is low. A draw item walks 256 accumulator words,
//   a read item returns one colored pixel.
//   Output: out_valid pulses for one cycle with out_item; it cannot be held
//   off, so results must be taken when they appear. Draw items give none.
//   Config: APB registers at paddr 0 (brightness), 4, 8, 12, 16 (red, green,
//   blue, alpha scales); write only while the block is idle.
//   Path: a read item passes the front registers and the queue, then the
//   registered tile read, and its result is registered to out_item.
//   Throughput: a draw item occupies the accumulator walk for a pop, a run of
//   read-modify-writes, one per cycle on the tile memory, and a drain; a
//   read item takes a pop and a read there. A two-stage front and a 2-entry
//   queue let further items enter while a walk is running.
//   Reset: registers return to their defaults, then the tile is cleared one
//   word per cycle, every word in turn, while busy stays high.
// ----------------------------------------------------------------------------
module line_accumulation_tile_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lat_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output lat_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lat_pkg::*;

  cfg_t      cfg_r;
  q_status_t q_stat;
  cmd_t      push_cmd;
  cmd_t      head;
  logic      push;
  logic      pop;
  logic      clearing;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness  <= BRIGHTNESS_RST;
      cfg_r.color_red   <= COLOR_RED_RST;
      cfg_r.color_green <= COLOR_GREEN_RST;
      cfg_r.color_blue  <= COLOR_BLUE_RST;
      cfg_r.color_alpha <= COLOR_ALPHA_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_BRIGHTNESS:  cfg_r.brightness  <= pwdata;
        REG_COLOR_RED:   cfg_r.color_red   <= pwdata[7:0];
        REG_COLOR_GREEN: cfg_r.color_green <= pwdata[7:0];
        REG_COLOR_BLUE:  cfg_r.color_blue  <= pwdata[7:0];
        REG_COLOR_ALPHA: cfg_r.color_alpha <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BRIGHTNESS:  prdata = cfg_r.brightness;
      REG_COLOR_RED:   prdata = {24'd0, cfg_r.color_red};
      REG_COLOR_GREEN: prdata = {24'd0, cfg_r.color_green};
      REG_COLOR_BLUE:  prdata = {24'd0, cfg_r.color_blue};
      REG_COLOR_ALPHA: prdata = {24'd0, cfg_r.color_alpha};
      default:         prdata = '0;
    endcase
  end

  lat_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .hold    (clearing),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_stat  (q_stat),
    .push    (push),
    .cmd     (push_cmd)
  );

  lat_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  lat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_stat.valid),
    .q_cmd     (head),
    .q_pop     (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> busy)
    else $error("item accepted during tile clear");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("queue push while full");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("queue pop while empty");

  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");
`endif

endmodule

@@ rtl/lat_ram.sv @@
// ----------------------------------------------------------------------------
// lat_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/lat_front.sv @@
// ----------------------------------------------------------------------------
// lat_front
// Accepts items, picks the major axis and forms the minor start and step.
// ----------------------------------------------------------------------------
module lat_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 hold,
  input  logic                 start,
  input  lat_pkg::in_item_t    in_item,
  output logic                 busy,
  input  lat_pkg::q_status_t   q_stat,
  output logic                 push,
  output lat_pkg::cmd_t        cmd
);
  import lat_pkg::*;

  typedef struct packed {
    logic               kind;
    logic               y_major;
    logic [15:0]        mn0;
    logic [7:0]         mj0_hi;
    logic [15:0]        d;
    logic [TILE_AW-1:0] raddr;
  } cls_t;

  in_item_t    a_r;
  logic        a_vld_r;
  cls_t        b_r;
  logic        b_vld_r;
  cls_t        cls;
  logic [15:0] xd;
  logic [15:0] yd;
  logic [15:0] mn1;
  logic [15:0] mj0;
  logic [23:0] prod;
  logic        a_go;
  logic        b_go;
  logic        accept;

  always_comb begin
    xd = (a_r.line_x_start > a_r.line_x_end) ? a_r.line_x_start - a_r.line_x_end
                                             : a_r.line_x_end - a_r.line_x_start;
    yd = (a_r.line_y_start > a_r.line_y_end) ? a_r.line_y_start - a_r.line_y_end
                                             : a_r.line_y_end - a_r.line_y_start;
    cls.kind    = a_r.kind;
    cls.y_major = (xd < yd);
    cls.mn0     = cls.y_major ? a_r.line_x_start : a_r.line_y_start;
    mn1         = cls.y_major ? a_r.line_x_end   : a_r.line_y_end;
    mj0         = cls.y_major ? a_r.line_y_start : a_r.line_x_start;
    cls.mj0_hi  = mj0[15:8];
    cls.d       = {8'd0, mn1[15:8]} - {8'd0, cls.mn0[15:8]};
    cls.raddr   = {a_r.read_row, a_r.read_col};
  end

  assign b_go   = b_vld_r && !q_stat.full;
  assign a_go   = a_vld_r && (!b_vld_r || b_go);
  assign busy   = hold || (a_vld_r && !a_go);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        a_vld_r <= 1'b1;
      end else if (a_go) begin
        a_vld_r <= 1'b0;
      end
      if (a_go) begin
        b_vld_r <= 1'b1;
      end else if (b_go) begin
        b_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= in_item;
    end
    if (a_go) begin
      b_r <= cls;
    end
  end

  assign prod = b_r.mj0_hi * b_r.d;

  always_comb begin
    cmd.kind    = b_r.kind;
    cmd.y_major = b_r.y_major;
    cmd.m0      = b_r.mn0 + prod[15:0];
    cmd.d       = b_r.d;
    cmd.raddr   = b_r.raddr;
  end

  assign push = b_go;

endmodule

@@ rtl/lat_queue.sv @@
// ----------------------------------------------------------------------------
// lat_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module lat_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lat_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output lat_pkg::cmd_t      head,
  output lat_pkg::q_status_t stat
);
  import lat_pkg::*;

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] cnt_r;

  assign stat.full  = (cnt_r == QCW'(QDEPTH));
  assign stat.valid = (cnt_r != '0);
  assign head       = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/lat_back.sv @@
// ----------------------------------------------------------------------------
// lat_back
// Clears the tile after reset, then walks lines and serves pixel reads.
// ----------------------------------------------------------------------------
module lat_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lat_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  lat_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  output lat_pkg::out_item_t  out_item
);
  import lat_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_RDATA
  } state_t;

  state_t             state_r;
  logic [TILE_AW-1:0] clr_cnt_r;
  logic [7:0]         i_r;
  logic [15:0]        m_r;
  logic [15:0]        d_r;
  logic               ymaj_r;
  logic               wr_pend_r;
  logic [TILE_AW-1:0] wr_addr_r;
  logic               out_vld_r;
  out_item_t          out_r;

  logic [TILE_AW-1:0] draw_addr;
  logic               rd_en;
  logic [TILE_AW-1:0] rd_addr;
  logic [31:0]        rd_data;
  logic               wr_en;
  logic [TILE_AW-1:0] wr_addr;
  logic [31:0]        wr_data;
  logic [32:0]        sum;
  logic [31:0]        cap;
  logic [31:0]        capped;
  logic [15:0]        red_p;
  logic [15:0]        green_p;
  logic [15:0]        blue_p;
  logic [15:0]        alpha_p;

  assign draw_addr = ymaj_r ? {i_r, m_r[15:8]} : {m_r[15:8], i_r};
  assign q_pop     = (state_r == ST_IDLE) && q_valid && !wr_pend_r;
  assign clearing  = (state_r == ST_CLEAR);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = draw_addr;
    unique case (state_r)
      ST_IDLE: begin
        rd_en   = q_pop;
        rd_addr = q_cmd.raddr;
      end
      ST_DRAW: begin
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign sum    = {1'b0, rd_data} + {1'b0, cfg.brightness};
  assign cap    = ~cfg.brightness;
  assign capped = (sum < {1'b0, cap}) ? sum[31:0] : cap;

  assign wr_en   = clearing || wr_pend_r;
  assign wr_addr = clearing ? clr_cnt_r : wr_addr_r;
  assign wr_data = clearing ? '0 : capped;

  lat_ram #(
    .WIDTH (32),
    .DEPTH (TILE_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign red_p   = rd_data[31:24] * cfg.color_red;
  assign green_p = rd_data[31:24] * cfg.color_green;
  assign blue_p  = rd_data[31:24] * cfg.color_blue;
  assign alpha_p = rd_data[31:24] * cfg.color_alpha;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      wr_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      wr_pend_r <= (state_r == ST_DRAW);
      out_vld_r <= (state_r == ST_RDATA);
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            state_r <= (q_cmd.kind == KIND_READ) ? ST_RDATA : ST_DRAW;
          end
        end
        ST_DRAW: begin
          if (i_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_RDATA: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_r    <= q_cmd.m0;
      d_r    <= q_cmd.d;
      ymaj_r <= q_cmd.y_major;
      i_r    <= '0;
    end else if (state_r == ST_DRAW) begin
      m_r <= m_r + d_r;
      i_r <= i_r + 1'b1;
    end
    if (state_r == ST_DRAW) begin
      wr_addr_r <= draw_addr;
    end
    if (state_r == ST_RDATA) begin
      out_r.red   <= red_p[15:8];
      out_r.green <= green_p[15:8];
      out_r.blue  <= blue_p[15:8];
      out_r.alpha <= alpha_p[15:8];
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_accumulation_tile_unit.
// Drives draw and read items, with random gaps, through the start/busy port.
// A tile copy in the bench works out each colored pixel that a read should
// return, and each pixel result is checked field by field in arrival order.
// Configuration goes through the APB port between phases and is read back.
// ----------------------------------------------------------------------------
module testbench;
  import lat_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 1600;
  localparam int RANDOM_ITEMS = 1925;
  localparam int PHASES       = 7;
  localparam logic [2:0] REG_SPARE = 3'd5;

  logic        clk;
  logic        rst_n;
  logic        start;
  in_item_t    in_item;
  logic        busy;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] tile_acc [TILE_WORDS];
  logic [15:0] line_addr [TILE_SIDE];
  bit          line_drawn;
  cfg_t        tile_cfg;
  out_item_t   pixel_q [$];
  out_item_t   pixel_want;
  int          errors;
  int          cycles = 0;

  line_accumulation_tile_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_item_t shade_pixel(logic [15:0] addr);
    logic [7:0]  top;
    logic [15:0] p;
    out_item_t   px;
    top = tile_acc[addr][31:24];
    p = top * tile_cfg.color_red;   px.red   = p[15:8];
    p = top * tile_cfg.color_green; px.green = p[15:8];
    p = top * tile_cfg.color_blue;  px.blue  = p[15:8];
    p = top * tile_cfg.color_alpha; px.alpha = p[15:8];
    return px;
  endfunction

  function automatic void walk_line(in_item_t it);
    logic [15:0] xd, yd, mn0, mn1, mj0, d, m, addr;
    logic        y_major;
    logic [32:0] sum;
    logic [31:0] cap;
    xd = (it.line_x_start > it.line_x_end) ? it.line_x_start - it.line_x_end
                                           : it.line_x_end - it.line_x_start;
    yd = (it.line_y_start > it.line_y_end) ? it.line_y_start - it.line_y_end
                                           : it.line_y_end - it.line_y_start;
    y_major = xd < yd;
    mn0 = y_major ? it.line_x_start : it.line_y_start;
    mn1 = y_major ? it.line_x_end   : it.line_y_end;
    mj0 = y_major ? it.line_y_start : it.line_x_start;
    d = {8'h00, mn1[15:8]} - {8'h00, mn0[15:8]};
    m = mn0 + mj0[15:8] * d;
    cap = 32'hFFFF_FFFF - tile_cfg.brightness;
    for (int i = 0; i < TILE_SIDE; i++) begin
      addr = y_major ? {i[7:0], m[15:8]} : {m[15:8], i[7:0]};
      sum = {1'b0, tile_acc[addr]} + {1'b0, tile_cfg.brightness};
      tile_acc[addr] = (sum < {1'b0, cap}) ? sum[31:0] : cap;
      line_addr[i] = addr;
      m = m + d;
    end
    line_drawn = 1'b1;
  endfunction

  function automatic in_item_t line_item(logic [15:0] x0, logic [15:0] y0,
                                         logic [15:0] x1, logic [15:0] y1);
    in_item_t it;
    it = '0;
    it.kind = KIND_DRAW;
    it.line_x_start = x0;
    it.line_y_start = y0;
    it.line_x_end   = x1;
    it.line_y_end   = y1;
    return it;
  endfunction

  function automatic in_item_t pixel_on_line(int step);
    in_item_t it;
    it = '0;
    it.kind = KIND_READ;
    it.read_col = line_addr[step][7:0];
    it.read_row = line_addr[step][15:8];
    return it;
  endfunction

  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    logic [15:0] addr;
    it.line_x_start = rand_coord();
    it.line_y_start = rand_coord();
    it.line_x_end   = rand_coord();
    it.line_y_end   = rand_coord();
    it.read_col     = 8'($urandom);
    it.read_row     = 8'($urandom);
    if ($urandom_range(99) < 45) begin
      it.kind = KIND_DRAW;
    end else begin
      it.kind = KIND_READ;
      if (line_drawn && $urandom_range(99) < 75) begin
        addr = line_addr[$urandom_range(TILE_SIDE - 1)];
        it.read_col = addr[7:0];
        it.read_row = addr[15:8];
      end
    end
    return it;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic send_item(in_item_t it, int gap);
    @(negedge clk);
    start = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    if (it.kind == KIND_READ) pixel_q.push_back(shade_pixel({it.read_row, it.read_col}));
    else walk_line(it);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BRIGHTNESS:  tile_cfg.brightness  = value;
      REG_COLOR_RED:   tile_cfg.color_red   = value[7:0];
      REG_COLOR_GREEN: tile_cfg.color_green = value[7:0];
      REG_COLOR_BLUE:  tile_cfg.color_blue  = value[7:0];
      REG_COLOR_ALPHA: tile_cfg.color_alpha = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_reg(logic [2:0] idx, logic [31:0] want, logic [31:0] mask);
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata & mask;
    if (got !== want) begin
      errors++;
      $display("%0t ns: register %0d expected %h, got %h", $time, idx, want, got);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_all_regs();
    check_reg(REG_BRIGHTNESS,  tile_cfg.brightness,         32'hFFFF_FFFF);
    check_reg(REG_COLOR_RED,   {24'h0, tile_cfg.color_red},   32'h0000_00FF);
    check_reg(REG_COLOR_GREEN, {24'h0, tile_cfg.color_green}, 32'h0000_00FF);
    check_reg(REG_COLOR_BLUE,  {24'h0, tile_cfg.color_blue},  32'h0000_00FF);
    check_reg(REG_COLOR_ALPHA, {24'h0, tile_cfg.color_alpha}, 32'h0000_00FF);
  endtask

  task automatic test_reset_state();
    in_item_t it;
    while (busy !== 1'b0) @(posedge clk);
    check_all_regs();
    it = '0;
    it.kind = KIND_READ;
    send_item(it, 0);
    it.read_col = 8'hFF;
    it.read_row = 8'hFF;
    send_item(it, 1);
    it.read_col = 8'h80;
    it.read_row = 8'h07;
    send_item(it, 0);
  endtask

  task automatic test_directed_lines();
    in_item_t it;
    settle();
    cfg_write(REG_BRIGHTNESS, 32'h0200_0000);
    cfg_write(REG_COLOR_RED, 32'd255);
    cfg_write(REG_COLOR_GREEN, 32'd0);
    cfg_write(REG_COLOR_BLUE, 32'd128);
    cfg_write(REG_COLOR_ALPHA, 32'd1);
    check_all_regs();
    // equal extents: x is major
    it = line_item(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    it.read_col = 8'hFF;
    it.read_row = 8'hFF;
    send_item(it, 0);
    send_item(pixel_on_line(255), 0);
    send_item(line_item(16'h0000, 16'h0000, 16'h0100, 16'hFFFF), 0);
    send_item(pixel_on_line(0), 0);
    // reversed x endpoints, positive minor delta
    send_item(line_item(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF), 2);
    send_item(pixel_on_line(128), 0);
    send_item(line_item(16'h0000, 16'h0000, 16'h0000, 16'h0000), 0);
    send_item(line_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
    // endpoint fields are ignored on a read
    it = line_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    it.kind = KIND_READ;
    it.read_col = 8'hFF;
    it.read_row = 8'hFF;
    send_item(it, 3);
    send_item(line_item(16'h8000, 16'h0000, 16'h7F00, 16'hFFFF), 0);
    send_item(pixel_on_line(7), 0);
  endtask

  task automatic test_cap_limits();
    in_item_t l;
    l = line_item(16'h1000, 16'h2000, 16'hE000, 16'h9000);
    settle();
    cfg_write(REG_COLOR_RED, 32'd255);
    cfg_write(REG_COLOR_GREEN, 32'd255);
    cfg_write(REG_COLOR_BLUE, 32'd255);
    cfg_write(REG_COLOR_ALPHA, 32'd255);
    // halve brightness each pass so the line climbs to the top byte
    for (int k = 0; k <= 8; k++) begin
      settle();
      cfg_write(REG_BRIGHTNESS, 32'h8000_0000 >> k);
      send_item(l, 0);
    end
    send_item(pixel_on_line(100), 0);
    // full brightness leaves no headroom: touched pixels drop to zero
    settle();
    cfg_write(REG_BRIGHTNESS, 32'hFFFF_FFFF);
    send_item(l, 0);
    send_item(pixel_on_line(100), 0);
  endtask

  task automatic test_random_traffic();
    logic [31:0] level;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: level = 32'h0100_0000;
        1: level = 32'h00FF_FFFF;
        2: level = 32'h0000_0000;
        3: level = $urandom_range(32'h0010_0000, 32'h1000_0000);
        4: level = 32'h4000_0000;
        5: level = 32'hFFFF_FFFF;
        default: level = $urandom;
      endcase
      cfg_write(REG_BRIGHTNESS, level);
      cfg_write(REG_COLOR_RED,
                32'((p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom)));
      cfg_write(REG_COLOR_GREEN,
                32'((p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom)));
      cfg_write(REG_COLOR_BLUE,
                32'((p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom)));
      cfg_write(REG_COLOR_ALPHA,
                32'((p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom)));
      if (p == 3) cfg_write(REG_SPARE, $urandom);
      check_all_regs();
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) send_item(random_item(), rand_gap());
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t ns: pixel with none expected, got %h", $time, out_item);
      end else begin
        pixel_want = pixel_q.pop_front();
        compare_field("red",   pixel_want.red,   out_item.red);
        compare_field("green", pixel_want.green, out_item.green);
        compare_field("blue",  pixel_want.blue,  out_item.blue);
        compare_field("alpha", pixel_want.alpha, out_item.alpha);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    line_drawn = 1'b0;
    for (int i = 0; i < TILE_WORDS; i++) tile_acc[i] = '0;
    for (int i = 0; i < TILE_SIDE; i++) line_addr[i] = '0;
    tile_cfg.brightness  = BRIGHTNESS_RST;
    tile_cfg.color_red   = COLOR_RED_RST;
    tile_cfg.color_green = COLOR_GREEN_RST;
    tile_cfg.color_blue  = COLOR_BLUE_RST;
    tile_cfg.color_alpha = COLOR_ALPHA_RST;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed_lines();
    test_cap_limits();
    test_random_traffic();
    settle();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
